### sv/adpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpp_pkg
// Shared types and constants of the ArtDmx pixel packetizer.
// ----------------------------------------------------------------------------
package adpp_pkg;

    localparam int PIXELS_PER_PACKET_DEF = 170;
    localparam int MAX_FRAME_PIXELS_DEF  = 16384;
    localparam int QUEUE_DEPTH_DEF       = 4;

    localparam int CFG_W   = 15;
    localparam int COLOR_W = 16;
    localparam logic [CFG_W-1:0] FRAME_PIXELS_RST = CFG_W'(170);

    localparam int BIDX_W = 5;
    localparam logic [BIDX_W-1:0] BIDX_OPC_LO   = BIDX_W'(8);
    localparam logic [BIDX_W-1:0] BIDX_OPC_HI   = BIDX_W'(9);
    localparam logic [BIDX_W-1:0] BIDX_VER_HI   = BIDX_W'(10);
    localparam logic [BIDX_W-1:0] BIDX_VER_LO   = BIDX_W'(11);
    localparam logic [BIDX_W-1:0] BIDX_SEQ      = BIDX_W'(12);
    localparam logic [BIDX_W-1:0] BIDX_PHYS     = BIDX_W'(13);
    localparam logic [BIDX_W-1:0] BIDX_UNIV_LO  = BIDX_W'(14);
    localparam logic [BIDX_W-1:0] BIDX_UNIV_HI  = BIDX_W'(15);
    localparam logic [BIDX_W-1:0] BIDX_LEN_HI   = BIDX_W'(16);
    localparam logic [BIDX_W-1:0] BIDX_LEN_LO   = BIDX_W'(17);
    localparam logic [BIDX_W-1:0] BIDX_RED      = BIDX_W'(18);
    localparam logic [BIDX_W-1:0] BIDX_GREEN    = BIDX_W'(19);
    localparam logic [BIDX_W-1:0] BIDX_BLUE     = BIDX_W'(20);

    localparam logic [7:0] OPCODE_DMX   = 8'h50;
    localparam logic [7:0] PROT_VERSION = 8'd14;

    localparam logic [7:0] ART_ID [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    typedef struct packed {
        logic        hdr;
        logic [7:0]  seq;
        logic [14:0] univ;
        logic [15:0] len3;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        endp;
        logic        endf;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### sv/adpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpp_front
// Accepts pixels, tracks packet and frame position, builds queue entries.
// ----------------------------------------------------------------------------
module adpp_front #(
    parameter int PIXELS_PER_PACKET = adpp_pkg::PIXELS_PER_PACKET_DEF,
    parameter int MAX_FRAME_PIXELS  = adpp_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [adpp_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_accept,
    input  logic [adpp_pkg::COLOR_W-1:0]   i_red,
    input  logic [adpp_pkg::COLOR_W-1:0]   i_green,
    input  logic [adpp_pkg::COLOR_W-1:0]   i_blue,
    output adpp_pkg::t_item                o_item
);
    import adpp_pkg::*;

    localparam int SW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int CW = (SW > CFG_W) ? SW : CFG_W;
    localparam logic [CW-1:0] MAX_FP = CW'(MAX_FRAME_PIXELS);
    localparam logic [CW-1:0] PPP_CW = CW'(PIXELS_PER_PACKET);
    localparam logic [7:0]    PPP_8  = 8'(PIXELS_PER_PACKET);

    logic [CFG_W-1:0] r_cfg;
    logic [7:0]       r_seq,  n_seq;
    logic [14:0]      r_univ, n_univ;
    logic [CW-1:0]    r_sent, n_sent;
    logic [7:0]       r_pix,  n_pix;
    logic [7:0]       r_len,  n_len;
    logic             r_last, n_last;

    logic [CW-1:0] cfg_ext, fp, base_sent, remaining;
    logic [14:0]   base_univ;
    logic          hdr, restart, new_last;
    logic [7:0]    new_len, pix_inc;
    logic          endp, endf;

    function automatic logic [7:0] sat8(input logic [COLOR_W-1:0] v);
        return (|v[COLOR_W-1:8]) ? 8'hFF : v[7:0];
    endfunction

    always_comb begin
        cfg_ext = CW'(r_cfg);
        if (cfg_ext == '0) begin
            fp = CW'(1);
        end else if (cfg_ext > MAX_FP) begin
            fp = MAX_FP;
        end else begin
            fp = cfg_ext;
        end
        hdr       = (r_pix == 8'd0);
        restart   = (r_sent >= fp);
        base_sent = restart ? '0 : r_sent;
        base_univ = restart ? '0 : r_univ;
        remaining = fp - base_sent;
        new_last  = (remaining <= PPP_CW);
        new_len   = new_last ? remaining[7:0] : PPP_8;

        n_seq  = r_seq;
        n_len  = r_len;
        n_last = r_last;
        if (hdr) begin
            n_seq  = r_seq + 8'd1;
            n_len  = new_len;
            n_last = new_last;
        end else begin
            base_sent = r_sent;
            base_univ = r_univ;
        end

        pix_inc = r_pix + 8'd1;
        endp    = (pix_inc >= n_len);
        endf    = endp && n_last;

        n_pix  = pix_inc;
        n_sent = base_sent;
        n_univ = base_univ;
        if (endp) begin
            n_pix = 8'd0;
            if (endf) begin
                n_sent = '0;
                n_univ = '0;
            end else begin
                n_sent = base_sent + PPP_CW;
                n_univ = base_univ + 15'd1;
            end
        end

        o_item.hdr   = hdr;
        o_item.seq   = r_seq;
        o_item.univ  = base_univ;
        o_item.len3  = {7'd0, new_len, 1'b0} + {8'd0, new_len};
        o_item.red   = sat8(i_red);
        o_item.green = sat8(i_green);
        o_item.blue  = sat8(i_blue);
        o_item.endp  = endp;
        o_item.endf  = endf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= FRAME_PIXELS_RST;
            r_seq  <= 8'd1;
            r_univ <= '0;
            r_sent <= '0;
            r_pix  <= '0;
            r_len  <= '0;
            r_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_seq  <= n_seq;
                r_univ <= n_univ;
                r_sent <= n_sent;
                r_pix  <= n_pix;
                r_len  <= n_len;
                r_last <= n_last;
            end
        end
    end

`ifndef SYNTH
    a_pix_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix == 8'd0 || r_pix < r_len)
        else $error("pixel position beyond latched packet length");
    a_endf_endp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item.endf |-> o_item.endp)
        else $error("frame end without packet end");
    a_reset_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_item.endf |=> r_pix == 8'd0 && r_univ == '0 && r_sent == '0)
        else $error("counters not cleared after frame end");
`endif

endmodule

### sv/adpp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpp_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module adpp_queue #(
    parameter int DEPTH = adpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adpp_pkg::t_item     i_item,
    input  logic                i_pop,
    output adpp_pkg::t_item     o_head,
    output adpp_pkg::t_q_status o_status
);
    import adpp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == NW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### sv/adpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpp_back
// Serializes queue entries into header and colour bytes, one per beat.
// ----------------------------------------------------------------------------
module adpp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adpp_pkg::t_item     i_head,
    input  adpp_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,
    output logic                m_axis_tlast,
    output logic                m_axis_tuser
);
    import adpp_pkg::*;

    logic [BIDX_W-1:0] r_idx;
    logic [BIDX_W-1:0] cur;
    logic              r_valid;
    logic [7:0]        r_data, n_data;
    logic              r_last, r_user;
    logic              advance, take, at_end;

    always_comb begin
        cur = (r_idx == '0 && !i_head.hdr) ? BIDX_RED : r_idx;
        case (cur)
            BIDX_OPC_LO:  n_data = 8'h00;
            BIDX_OPC_HI:  n_data = OPCODE_DMX;
            BIDX_VER_HI:  n_data = 8'h00;
            BIDX_VER_LO:  n_data = PROT_VERSION;
            BIDX_SEQ:     n_data = i_head.seq;
            BIDX_PHYS:    n_data = 8'h00;
            BIDX_UNIV_LO: n_data = i_head.univ[7:0];
            BIDX_UNIV_HI: n_data = {1'b0, i_head.univ[14:8]};
            BIDX_LEN_HI:  n_data = i_head.len3[15:8];
            BIDX_LEN_LO:  n_data = i_head.len3[7:0];
            BIDX_RED:     n_data = i_head.red;
            BIDX_GREEN:   n_data = i_head.green;
            BIDX_BLUE:    n_data = i_head.blue;
            default:      n_data = ART_ID[cur[2:0]];
        endcase
        at_end  = (cur == BIDX_BLUE);
        advance = !r_valid || m_axis_tready;
        take    = advance && !i_status.empty;
        o_pop   = take && at_end;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_user;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
            r_last <= at_end && i_head.endp;
            r_user <= at_end && i_head.endf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_status.empty;
            end
            if (take) begin
                r_idx <= at_end ? '0 : cur + BIDX_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_user_implies_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end flag without packet end flag");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= BIDX_BLUE)
        else $error("byte index out of range");
    a_idx_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> !i_status.empty)
        else $error("entry in progress but queue empty");
`endif

endmodule

### sv/artdmx_pixel_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// artdmx_pixel_packetizer
// Cuts a frame of RGB pixels into ArtDmx packets and streams their bytes.
//
//   port group      dir  payload
//   s_axis_*        in   tdata: red[15:0], green[31:16], blue[47:32]
//   m_axis_*        out  tdata: packet_byte; tlast: last_of_packet;
//                        tuser: last_of_frame
//   i_cfg_*         in   frame_pixels, written when i_cfg_we is high
//
// Output runs at one byte per cycle while m_axis_tready is high and the queue
// holds an entry: three bytes per pixel, 21 for a pixel that opens a packet (18 header bytes plus its colour bytes).
// The front takes a pixel in any cycle the queue has room, so pixels arrive
// back to back while the serializer drains header bytes.
// Reset is synchronous, active low; it clears counters, queue and output.
// Output stalls hold the byte register; the queue then fills and deasserts
// s_axis_tready.
// ----------------------------------------------------------------------------
module artdmx_pixel_packetizer #(
    parameter int PIXELS_PER_PACKET = adpp_pkg::PIXELS_PER_PACKET_DEF,
    parameter int MAX_FRAME_PIXELS  = adpp_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int QUEUE_DEPTH       = adpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [adpp_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [3*adpp_pkg::COLOR_W-1:0] s_axis_tdata,  // red, green, blue
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // packet_byte
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser   // last_of_frame
);
    import adpp_pkg::*;

    t_item     front_item, head;
    t_q_status q_status;
    logic      accept, pop;

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && !q_status.full;

    adpp_front #(
        .PIXELS_PER_PACKET (PIXELS_PER_PACKET),
        .MAX_FRAME_PIXELS  (MAX_FRAME_PIXELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_red       (s_axis_tdata[COLOR_W-1:0]),
        .i_green     (s_axis_tdata[2*COLOR_W-1:COLOR_W]),
        .i_blue      (s_axis_tdata[3*COLOR_W-1:2*COLOR_W]),
        .o_item      (front_item)
    );

    adpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    adpp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_status      (q_status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### sim/artdmx_pixel_packetizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// artdmx_pixel_packetizer_test
// Sends RGB pixels and frame-size writes into the packetizer. Predicts each
// packet byte with its end-of-packet and end-of-frame flags, and compares
// every output beat in order against the prediction.
// ----------------------------------------------------------------------------
module artdmx_pixel_packetizer_test;
    import adpp_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       eop;
        logic       eof;
    } t_out_byte;

    class artdmx_packet_tracker;
        logic [CFG_W-1:0] frame_size;
        logic [7:0]       seq_no;
        logic [14:0]      universe;
        int unsigned      packets_sent;
        logic [7:0]       pixel_idx;
        int unsigned      pkt_pixels;
        bit               pkt_is_last;
        int unsigned      byte_errors;
        t_out_byte        due_bytes[$];

        function new();
            frame_size   = FRAME_PIXELS_RST;
            seq_no       = 8'd1;
            universe     = '0;
            packets_sent = 0;
            pixel_idx    = '0;
            pkt_pixels   = 0;
            pkt_is_last  = 1'b0;
            byte_errors  = 0;
        endfunction

        function logic [7:0] clip(logic [COLOR_W-1:0] level);
            return (level > 16'd255) ? 8'hFF : level[7:0];
        endfunction

        function void push(logic [7:0] value, logic eop = 1'b0, logic eof = 1'b0);
            t_out_byte b;
            b.value = value;
            b.eop   = eop;
            b.eof   = eof;
            due_bytes.push_back(b);
        endfunction

        function void note_error(string msg);
            byte_errors++;
            if (byte_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
        endfunction

        function void take_pixel(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                 logic [COLOR_W-1:0] blue);
            int unsigned fp;
            int unsigned sent;
            int unsigned remaining;
            logic [15:0] len3;
            bit          endp;
            bit          endf;
            int          k;
            if (pixel_idx == 0) begin
                fp = frame_size;
                if (fp == 0) fp = 1;
                if (fp > MAX_FRAME_PIXELS_DEF) fp = MAX_FRAME_PIXELS_DEF;
                sent = packets_sent * PIXELS_PER_PACKET_DEF;
                if (sent >= fp) begin
                    packets_sent = 0;
                    universe     = '0;
                    sent         = 0;
                end
                remaining   = fp - sent;
                pkt_is_last = remaining <= PIXELS_PER_PACKET_DEF;
                pkt_pixels  = pkt_is_last ? remaining : PIXELS_PER_PACKET_DEF;
                len3        = 16'(pkt_pixels * 3);
                for (k = 0; k < 8; k++) push(ART_ID[k]);
                push(8'h00);
                push(OPCODE_DMX);
                push(8'h00);
                push(PROT_VERSION);
                push(seq_no);
                push(8'h00);
                push(universe[7:0]);
                push({1'b0, universe[14:8]});
                push(len3[15:8]);
                push(len3[7:0]);
                seq_no = seq_no + 8'd1;
            end
            pixel_idx = pixel_idx + 8'd1;
            endp = pixel_idx >= pkt_pixels;
            endf = endp && pkt_is_last;
            push(clip(red));
            push(clip(green));
            push(clip(blue), endp, endf);
            if (endp) begin
                pixel_idx = '0;
                if (endf) begin
                    packets_sent = 0;
                    universe     = '0;
                end else begin
                    packets_sent++;
                    universe = universe + 15'd1;
                end
            end
        endfunction

        function void match_byte(logic [7:0] value, logic eop, logic eof);
            t_out_byte want;
            if (due_bytes.size() == 0) begin
                note_error($sformatf("unexpected beat: byte %02h tlast %0b tuser %0b",
                                     value, eop, eof));
                return;
            end
            want = due_bytes.pop_front();
            if (want.value !== value || want.eop !== eop || want.eof !== eof) begin
                note_error($sformatf("byte %02h tlast %0b tuser %0b, got %02h %0b %0b",
                                     want.value, want.eop, want.eof, value, eop, eof));
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [3*COLOR_W-1:0] s_axis_tdata  = '0;  // red, green, blue
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // packet_byte
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;        // last_of_frame

    artdmx_packet_tracker tracker = new();

    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    int unsigned pixels_sent = 0;
    int          stall_left  = 0;
    int unsigned idle_cycles = 0;

    artdmx_pixel_packetizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(7, 0) == 0) begin
            stall_left = $urandom_range(11, 1) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.match_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("artdmx_pixel_packetizer_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [COLOR_W-1:0] random_level();
        case ($urandom_range(7, 0))
            0, 1: return COLOR_W'($urandom);
            2, 3: return COLOR_W'($urandom_range(255, 0));
            4: return 16'h00FF;
            5: return 16'h0100;
            6: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_pixel(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] blue);
        if (gaps_on && $urandom_range(3, 0) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_pixel(red, green, blue);
        pixels_sent++;
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        while (tracker.due_bytes.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.frame_size = size;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] size, input int unsigned count);
        write_frame_size(size);
        repeat (count) send_pixel(random_level(), random_level(), random_level());
    endtask

    initial begin
        logic [CFG_W-1:0] size;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_frame_size(15'd3);
        send_pixel(16'h0000, 16'h00FF, 16'h0100);
        // hold the open packet's length across the write
        write_frame_size(15'd0);
        send_pixel(16'hFFFF, 16'h0001, 16'h00FE);
        send_pixel(16'h7FFF, 16'h8000, 16'hAAAA);
        send_pixel(16'h5555, 16'h0000, 16'hFFFF);
        send_pixel(16'h00FF, 16'hFFFF, 16'h0000);
        write_frame_size(15'd4);
        send_pixel(16'h0101, 16'h00FE, 16'hFF00);
        send_pixel(16'h0080, 16'h0100, 16'h00FF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        write_frame_size(15'd2);
        send_pixel(16'h0100, 16'h0000, 16'h00FF);
        send_pixel(16'h8000, 16'h7FFF, 16'h0001);

        // one full packet, then shrink the frame below what was sent
        run_phase(15'h7FFF, 170);

        while (pixels_sent < 334) begin
            gaps_on   = $urandom_range(3, 0) != 0;
            stalls_on <= $urandom_range(3, 0) != 0;
            case ($urandom_range(15, 0))
                0, 1, 2, 3, 4, 5, 6: size = 15'd1;
                7, 8, 9: size = 15'd2;
                10, 11, 12: size = CFG_W'($urandom_range(8, 3));
                13: size = '0;
                default: size = CFG_W'($urandom_range(60, 9));
            endcase
            run_phase(size, $urandom_range(20, 1));
        end

        gaps_on   = 1'b0;
        stalls_on <= 1'b0;
        run_phase(15'd2, 16);
        s_axis_tvalid <= 1'b0;
        while (tracker.due_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.due_bytes.size() != 0) begin
            tracker.note_error($sformatf("%0d bytes never arrived", tracker.due_bytes.size()));
        end
        if (tracker.byte_errors == 0) begin
            $display("artdmx_pixel_packetizer_test passed");
        end else begin
            $display("artdmx_pixel_packetizer_test failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/adpp_pkg.sv
sv/adpp_front.sv
sv/adpp_queue.sv
sv/adpp_back.sv
sv/artdmx_pixel_packetizer.sv
sim/artdmx_pixel_packetizer_test.sv
